// File: design/rts_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the run-length tilemap row scroller.
// No dependencies; the other design files, apart from rts_ram, refer to this package by scoped names.
package rts_pkg;

    localparam int MAP_BYTES        = 4096;
    localparam int MAP_AW           = $clog2(MAP_BYTES);
    localparam int CODE_W           = MAP_AW + 1;
    localparam int ROW_CHARS        = 16;
    localparam int CHAR_IW          = $clog2(ROW_CHARS);
    localparam int FILL_W           = CHAR_IW + 1;
    localparam int EMIT_W           = CHAR_IW + 2;
    localparam int SCROLL_CHAR_ROWS = 28;
    localparam int SCROLL_LINES     = 224;

    localparam int ADDR_W  = 12;
    localparam int BYTE_W  = 8;
    localparam int BASE_W  = 9;
    localparam int COL_W   = 5;
    localparam int ROW_W   = 5;
    localparam int TILE_W  = 11;
    localparam int SCR_W   = 8;
    localparam int CNT_W   = 4;
    localparam int RUN_W   = 7;
    localparam int APB_AW  = 3;

    localparam logic [BYTE_W-1:0] END_MARK     = 8'hFF;
    localparam logic [CNT_W-1:0]  COUNT_RELOAD = 4'd15;
    localparam logic [BASE_W-1:0] TILE_BASE_RST = 9'd256;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic REG_LEVEL_START = 1'b0;
    localparam logic REG_TILE_BASE   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_CODE,
        ST_WT_CODE,
        ST_RD_DATA,
        ST_WT_DATA,
        ST_REPEAT,
        ST_CHECK,
        ST_RD_END,
        ST_WT_END,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load_byte;
        logic tick;
        logic take_code;
        logic take_data;
        logic rep_step;
        logic take_end;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic is_run;
        logic rep_active;
        logic row_done;
        logic slot_free;
        logic emit_last;
    } t_dp_status;

endpackage

// File: design/rts_item_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input items and result items.
// Depends on rts_pkg for field widths.
interface rts_item_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [rts_pkg::ADDR_W-1:0]  load_address;
    logic [rts_pkg::BYTE_W-1:0]  load_byte;

    modport source (output valid, output opcode, output load_address, output load_byte,
                    input ready);
    modport sink   (input valid, input opcode, input load_address, input load_byte,
                    output ready);
endinterface

interface rts_result_if;
    logic                        valid;
    logic                        ready;
    logic                        tile_valid;
    logic [rts_pkg::COL_W-1:0]   tile_column;
    logic [rts_pkg::ROW_W-1:0]   tile_row;
    logic [rts_pkg::TILE_W-1:0]  tile_value;
    logic [rts_pkg::SCR_W-1:0]   scroll_value;
    logic                        last;

    modport source (output valid, output tile_valid, output tile_column, output tile_row,
                    output tile_value, output scroll_value, output last, input ready);
    modport sink   (input valid, input tile_valid, input tile_column, input tile_row,
                    input tile_value, input scroll_value, input last, output ready);
endinterface

// File: design/rts_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
// No dependencies.
module rts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/rts_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the row scroller: item handshake, row decode steps and tile emission.
// Depends on rts_pkg; drives rts_datapath through t_dp_cmd and reads t_dp_status.
module rts_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_opcode,
    output logic                o_in_ready,
    input  rts_pkg::t_dp_status i_st,
    output rts_pkg::t_dp_cmd    o_cmd
);

    rts_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rts_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            rts_pkg::ST_IDLE: begin
                o_in_ready = i_st.slot_free;
                if (i_in_valid && i_st.slot_free) begin
                    if (i_in_opcode == rts_pkg::OP_LOAD) begin
                        o_cmd.load_byte = 1'b1;
                    end else begin
                        o_cmd.tick = 1'b1;
                        if (i_st.cnt_zero) begin
                            n_state = rts_pkg::ST_RD_CODE;
                        end
                    end
                end
            end
            rts_pkg::ST_RD_CODE: begin
                n_state = rts_pkg::ST_WT_CODE;
            end
            rts_pkg::ST_WT_CODE: begin
                o_cmd.take_code = 1'b1;
                n_state = i_st.is_run ? rts_pkg::ST_RD_DATA : rts_pkg::ST_CHECK;
            end
            rts_pkg::ST_RD_DATA: begin
                n_state = rts_pkg::ST_WT_DATA;
            end
            rts_pkg::ST_WT_DATA: begin
                o_cmd.take_data = 1'b1;
                n_state = rts_pkg::ST_REPEAT;
            end
            rts_pkg::ST_REPEAT: begin
                if (i_st.rep_active) begin
                    o_cmd.rep_step = 1'b1;
                end else begin
                    n_state = rts_pkg::ST_CHECK;
                end
            end
            rts_pkg::ST_CHECK: begin
                n_state = i_st.row_done ? rts_pkg::ST_RD_END : rts_pkg::ST_RD_CODE;
            end
            rts_pkg::ST_RD_END: begin
                n_state = rts_pkg::ST_WT_END;
            end
            rts_pkg::ST_WT_END: begin
                o_cmd.take_end = 1'b1;
                n_state = rts_pkg::ST_EMIT;
            end
            rts_pkg::ST_EMIT: begin
                if (i_st.slot_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_st.emit_last) begin
                        n_state = rts_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = rts_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/rts_datapath.sv
`timescale 1ns / 1ps
// Datapath: map memory, row character buffer, scroll state and the result register.
// Depends on rts_pkg and rts_ram; steered by rts_ctrl.
module rts_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rts_pkg::t_dp_cmd            i_cmd,
    output rts_pkg::t_dp_status         o_st,
    input  logic [rts_pkg::ADDR_W-1:0]  i_load_address,
    input  logic [rts_pkg::BYTE_W-1:0]  i_load_byte,
    input  logic [rts_pkg::ADDR_W-1:0]  i_level_start,
    input  logic [rts_pkg::BASE_W-1:0]  i_tile_base,
    input  logic                        i_ls_wr,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic                        o_tile_valid,
    output logic [rts_pkg::COL_W-1:0]   o_tile_column,
    output logic [rts_pkg::ROW_W-1:0]   o_tile_row,
    output logic [rts_pkg::TILE_W-1:0]  o_tile_value,
    output logic [rts_pkg::SCR_W-1:0]   o_scroll_value,
    output logic                        o_last
);

    logic [rts_pkg::MAP_AW-1:0]  r_ptr;
    logic [rts_pkg::ROW_W-1:0]   r_row;
    logic [rts_pkg::CNT_W-1:0]   r_cnt;
    logic [rts_pkg::SCR_W-1:0]   r_scroll;
    logic [rts_pkg::SCR_W-1:0]   r_scroll_item;
    logic [rts_pkg::BYTE_W-1:0]  r_chars [rts_pkg::ROW_CHARS];
    logic [rts_pkg::FILL_W-1:0]  r_fill;
    logic [rts_pkg::CODE_W-1:0]  r_codes;
    logic [rts_pkg::RUN_W-1:0]   r_rep;
    logic [rts_pkg::BYTE_W-1:0]  r_val;
    logic [rts_pkg::EMIT_W-1:0]  r_idx;

    logic                        r_ov;
    logic                        r_o_tile_valid;
    logic [rts_pkg::COL_W-1:0]   r_o_col;
    logic [rts_pkg::ROW_W-1:0]   r_o_row;
    logic [rts_pkg::TILE_W-1:0]  r_o_val;
    logic [rts_pkg::SCR_W-1:0]   r_o_scroll;
    logic                        r_o_last;

    logic [rts_pkg::MAP_AW-1:0]  w_ram_addr;
    logic [rts_pkg::BYTE_W-1:0]  w_rdata;
    logic                        w_slot_free;
    logic                        w_idx_last;
    logic                        w_line;
    logic                        w_odd;
    logic [rts_pkg::CHAR_IW-1:0] w_k;
    logic [rts_pkg::BYTE_W-1:0]  w_char;
    logic [rts_pkg::TILE_W-1:0]  w_tile;
    logic [rts_pkg::SCR_W-1:0]   w_scroll_next;
    logic [rts_pkg::ROW_W-1:0]   w_row_next;

    assign w_ram_addr = i_cmd.load_byte ? i_load_address[rts_pkg::MAP_AW-1:0] : r_ptr;

    rts_ram #(
        .WIDTH (rts_pkg::BYTE_W),
        .DEPTH (rts_pkg::MAP_BYTES)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_byte),
        .i_addr  (w_ram_addr),
        .i_wdata (i_load_byte),
        .o_rdata (w_rdata)
    );

    assign w_slot_free = !r_ov || i_out_ready;
    assign w_idx_last  = (r_idx == {rts_pkg::EMIT_W{1'b1}});
    assign w_line      = r_idx[rts_pkg::EMIT_W-1];
    assign w_k         = r_idx[rts_pkg::CHAR_IW:1];
    assign w_odd       = r_idx[0];
    assign w_char      = r_chars[w_k];

    // base + line + char*4, plus two for the right-hand tile of the pair
    assign w_tile = {2'b00, i_tile_base}
                  + {{(rts_pkg::TILE_W-1){1'b0}}, w_line}
                  + {1'b0, w_char, 2'b00}
                  + {{(rts_pkg::TILE_W-2){1'b0}}, w_odd, 1'b0};

    assign w_scroll_next = (r_scroll == '0) ? rts_pkg::SCR_W'(rts_pkg::SCROLL_LINES - 1)
                                            : r_scroll - 1'b1;
    assign w_row_next = (r_row >= rts_pkg::ROW_W'(2)) ? r_row - rts_pkg::ROW_W'(2)
                                                      : rts_pkg::ROW_W'(rts_pkg::SCROLL_CHAR_ROWS - 2);

    assign o_st.cnt_zero   = (r_cnt == '0);
    assign o_st.is_run     = w_rdata[rts_pkg::BYTE_W-1];
    assign o_st.rep_active = (r_rep != '0) && (r_fill != rts_pkg::FILL_W'(rts_pkg::ROW_CHARS));
    assign o_st.row_done   = (r_fill == rts_pkg::FILL_W'(rts_pkg::ROW_CHARS))
                          || (r_codes == rts_pkg::CODE_W'(rts_pkg::MAP_BYTES));
    assign o_st.slot_free  = w_slot_free;
    assign o_st.emit_last  = w_idx_last;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= '0;
            r_row    <= rts_pkg::ROW_W'(rts_pkg::SCROLL_CHAR_ROWS - 2);
            r_cnt    <= '0;
            r_scroll <= '0;
            r_fill   <= '0;
            r_codes  <= '0;
            r_idx    <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (i_ls_wr) begin
                r_ptr <= i_level_start[rts_pkg::MAP_AW-1:0];
            end
            if (i_cmd.tick) begin
                r_scroll <= w_scroll_next;
                if (r_cnt != '0) begin
                    r_cnt <= r_cnt - 1'b1;
                end else begin
                    r_fill  <= '0;
                    r_codes <= '0;
                    r_idx   <= '0;
                end
            end
            if (i_cmd.take_code) begin
                r_ptr   <= r_ptr + 1'b1;
                r_codes <= r_codes + 1'b1;
                if (!w_rdata[rts_pkg::BYTE_W-1]) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (i_cmd.take_data) begin
                r_ptr <= r_ptr + 1'b1;
            end
            if (i_cmd.rep_step) begin
                r_fill <= r_fill + 1'b1;
            end
            // end marker sends the pointer back to the start of the level
            if (i_cmd.take_end && (w_rdata == rts_pkg::END_MARK)) begin
                r_ptr <= i_level_start[rts_pkg::MAP_AW-1:0];
            end
            if (i_cmd.emit) begin
                r_idx <= r_idx + 1'b1;
                if (w_idx_last) begin
                    r_row <= w_row_next;
                    r_cnt <= rts_pkg::COUNT_RELOAD;
                end
            end
            if (i_cmd.emit || (i_cmd.tick && (r_cnt != '0))) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.tick) begin
            r_scroll_item <= r_scroll;
            if (r_cnt == '0) begin
                for (int i = 0; i < rts_pkg::ROW_CHARS; i++) begin
                    r_chars[i] <= '0;
                end
            end else begin
                r_o_tile_valid <= 1'b0;
                r_o_col        <= '0;
                r_o_row        <= '0;
                r_o_val        <= '0;
                r_o_scroll     <= r_scroll;
                r_o_last       <= 1'b1;
            end
        end
        if (i_cmd.take_code) begin
            if (w_rdata[rts_pkg::BYTE_W-1]) begin
                r_rep <= w_rdata[rts_pkg::RUN_W-1:0];
            end else begin
                r_chars[r_fill[rts_pkg::CHAR_IW-1:0]] <= w_rdata;
            end
        end
        if (i_cmd.take_data) begin
            r_val <= w_rdata;
        end
        if (i_cmd.rep_step) begin
            r_chars[r_fill[rts_pkg::CHAR_IW-1:0]] <= r_val;
            r_rep <= r_rep - 1'b1;
        end
        if (i_cmd.emit) begin
            r_o_tile_valid <= 1'b1;
            r_o_col        <= {w_k, w_odd};
            r_o_row        <= r_row + {{(rts_pkg::ROW_W-1){1'b0}}, w_line};
            r_o_val        <= w_tile;
            r_o_scroll     <= r_scroll_item;
            r_o_last       <= w_idx_last;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_tile_valid   = r_o_tile_valid;
    assign o_tile_column  = r_o_col;
    assign o_tile_row     = r_o_row;
    assign o_tile_value   = r_o_val;
    assign o_scroll_value = r_o_scroll;
    assign o_last         = r_o_last;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= rts_pkg::FILL_W'(rts_pkg::ROW_CHARS))
        else $error("row fill count overran the row");

    a_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && w_idx_last) |=> (r_cnt == rts_pkg::COUNT_RELOAD))
        else $error("countdown not reloaded after a row");

    a_last_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_tile_valid && r_o_last) |-> (r_o_col == {rts_pkg::COL_W{1'b1}}))
        else $error("final tile of a row not in the last column");

    a_quiet_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.tick && (r_cnt != '0)) |=> (r_ov && !r_o_tile_valid && r_o_last))
        else $error("quiet tick did not present a single closing result");

endmodule

// File: design/rle_tilemap_row_scroller.sv
`timescale 1ns / 1ps
// Top level: APB register file plus sequencer and datapath of the row scroller.
// Load item: written to map memory, no result. Tick while the countdown runs: result
// in the output register in the cycle after acceptance. Row tick: literal codes are
// stored, run codes repeat their data byte up to the clipped run length, the end marker
// is checked, then 64 results leave the output register, one per cycle unless stalled.
// Synchronous active-low reset clears control state; the map memory keeps its contents.
module rle_tilemap_row_scroller (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rts_pkg::APB_AW-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    rts_item_if.sink                     i_item,
    rts_result_if.source                 o_result
);

    logic [rts_pkg::ADDR_W-1:0] r_level_start;
    logic [rts_pkg::BASE_W-1:0] r_tile_base;
    logic                       w_cfg_wr;
    logic                       w_ls_wr;
    logic                       w_sel;
    logic [rts_pkg::ADDR_W-1:0] w_level_start;
    rts_pkg::t_dp_cmd           w_cmd;
    rts_pkg::t_dp_status        w_st;

    assign pready   = 1'b1;
    assign w_sel    = paddr[2];
    assign w_cfg_wr = psel && penable && pwrite;
    assign w_ls_wr  = w_cfg_wr && (w_sel == rts_pkg::REG_LEVEL_START);

    // the read pointer takes the level start being written, not the old one
    assign w_level_start = w_ls_wr ? pwdata[rts_pkg::ADDR_W-1:0] : r_level_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_start <= '0;
            r_tile_base   <= rts_pkg::TILE_BASE_RST;
        end else if (w_cfg_wr) begin
            if (w_sel == rts_pkg::REG_LEVEL_START) begin
                r_level_start <= pwdata[rts_pkg::ADDR_W-1:0];
            end else begin
                r_tile_base <= pwdata[rts_pkg::BASE_W-1:0];
            end
        end
    end

    always_comb begin
        case (w_sel)
            rts_pkg::REG_LEVEL_START: prdata = {{(32-rts_pkg::ADDR_W){1'b0}}, r_level_start};
            rts_pkg::REG_TILE_BASE:   prdata = {{(32-rts_pkg::BASE_W){1'b0}}, r_tile_base};
            default:                  prdata = '0;
        endcase
    end

    rts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_in_opcode (i_item.opcode),
        .o_in_ready  (i_item.ready),
        .i_st        (w_st),
        .o_cmd       (w_cmd)
    );

    rts_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_st           (w_st),
        .i_load_address (i_item.load_address),
        .i_load_byte    (i_item.load_byte),
        .i_level_start  (w_level_start),
        .i_tile_base    (r_tile_base),
        .i_ls_wr        (w_ls_wr),
        .i_out_ready    (o_result.ready),
        .o_out_valid    (o_result.valid),
        .o_tile_valid   (o_result.tile_valid),
        .o_tile_column  (o_result.tile_column),
        .o_tile_row     (o_result.tile_row),
        .o_tile_value   (o_result.tile_value),
        .o_scroll_value (o_result.scroll_value),
        .o_last         (o_result.last)
    );

endmodule

// File: test/rle_tilemap_row_scroller_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for rle_tilemap_row_scroller: map loads, frame ticks, register writes,
// with a cycle-free row decoder that predicts every tile write and scroll result.
// Depends on rts_pkg, the rts_item_if / rts_result_if interfaces and the top level.
module rle_tilemap_row_scroller_tb;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_ITEMS    = 86;
    localparam int REPORT_CAP     = 40;

    typedef struct packed {
        logic                       op;
        logic [rts_pkg::ADDR_W-1:0] addr;
        logic [rts_pkg::BYTE_W-1:0] data;
    } t_map_item;

    typedef struct packed {
        logic                       tile_valid;
        logic [rts_pkg::COL_W-1:0]  col;
        logic [rts_pkg::ROW_W-1:0]  row;
        logic [rts_pkg::TILE_W-1:0] tile;
        logic [rts_pkg::SCR_W-1:0]  scroll;
        logic                       last;
    } t_tile_write;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [rts_pkg::APB_AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rts_item_if   item_if ();
    rts_result_if res_if ();

    rle_tilemap_row_scroller DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .i_item   (item_if),
        .o_result (res_if)
    );

    // Predicted block state
    logic [rts_pkg::BYTE_W-1:0] map_mem [rts_pkg::MAP_BYTES];
    logic [rts_pkg::MAP_AW-1:0] rd_ptr;
    logic [rts_pkg::ROW_W-1:0]  row_pos;
    logic [rts_pkg::CNT_W-1:0]  line_cnt;
    logic [rts_pkg::SCR_W-1:0]  scroll_pos;
    logic [rts_pkg::MAP_AW-1:0] lvl_start;
    logic [rts_pkg::BASE_W-1:0] tile_base;

    t_map_item   item_q [$];
    t_tile_write tile_writes_q [$];
    t_map_item   cur_item;

    int err_n;
    int res_n;
    int gap_left;
    int stall_left;
    int hold_left;
    int hold_req_n;
    int hold_taken_n;
    int quiet_n;
    int src_idle_max;
    int snk_idle_max;
    int lvl_len;

    task automatic flag_mismatch(input string what);
        err_n++;
        if (err_n <= REPORT_CAP) begin
            $display("mismatch: %s", what);
        end
    endtask

    function automatic void push_item(input logic op, input logic [rts_pkg::ADDR_W-1:0] a,
                                      input logic [rts_pkg::BYTE_W-1:0] d);
        t_map_item it;
        it.op   = op;
        it.addr = a;
        it.data = d;
        item_q.push_back(it);
    endfunction

    function automatic void push_tick();
        push_item(rts_pkg::OP_TICK, rts_pkg::ADDR_W'($urandom_range(0, 4095)),
                  rts_pkg::BYTE_W'($urandom_range(0, 255)));
    endfunction

    // Decode one row from the read pointer and queue its 64 tile writes
    task automatic decode_row(input logic [rts_pkg::SCR_W-1:0] scr);
        logic [rts_pkg::BYTE_W-1:0] chars [rts_pkg::ROW_CHARS];
        logic [rts_pkg::MAP_AW-1:0] p;
        logic [rts_pkg::BYTE_W-1:0] code;
        logic [rts_pkg::BYTE_W-1:0] data;
        t_tile_write                w;
        int filled;
        int codes;
        int n;
        p      = rd_ptr;
        filled = 0;
        codes  = 0;
        for (int k = 0; k < rts_pkg::ROW_CHARS; k++) chars[k] = '0;
        while (filled < rts_pkg::ROW_CHARS && codes < rts_pkg::MAP_BYTES) begin
            code = map_mem[p];
            p++;
            codes++;
            if (code[7]) begin
                n    = int'(code[6:0]);
                data = map_mem[p];
                p++;
                while (n > 0 && filled < rts_pkg::ROW_CHARS) begin
                    chars[filled] = data;
                    filled++;
                    n--;
                end
            end else begin
                chars[filled] = code;
                filled++;
            end
        end
        rd_ptr = p;
        for (int ln = 0; ln < 2; ln++) begin
            for (int k = 0; k < rts_pkg::ROW_CHARS; k++) begin
                w.tile_valid = 1'b1;
                w.col        = rts_pkg::COL_W'(2 * k);
                w.row        = rts_pkg::ROW_W'(row_pos + ln);
                w.tile       = rts_pkg::TILE_W'(tile_base) + rts_pkg::TILE_W'(ln)
                             + (rts_pkg::TILE_W'(chars[k]) << 2);
                w.scroll     = scr;
                w.last       = 1'b0;
                tile_writes_q.push_back(w);
                w.col  = rts_pkg::COL_W'(2 * k + 1);
                w.tile = w.tile + rts_pkg::TILE_W'(2);
                w.last = (ln == 1 && k == rts_pkg::ROW_CHARS - 1);
                tile_writes_q.push_back(w);
            end
        end
        if (map_mem[rd_ptr] == rts_pkg::END_MARK) begin
            rd_ptr = lvl_start;
        end
        if (row_pos >= rts_pkg::ROW_W'(2)) begin
            row_pos = row_pos - rts_pkg::ROW_W'(2);
        end else begin
            row_pos = rts_pkg::ROW_W'(rts_pkg::SCROLL_CHAR_ROWS - 2);
        end
        line_cnt = rts_pkg::COUNT_RELOAD;
    endtask

    task automatic scroller_step(input t_map_item it);
        t_tile_write w;
        logic [rts_pkg::SCR_W-1:0] scr;
        if (it.op == rts_pkg::OP_LOAD) begin
            map_mem[it.addr] = it.data;
        end else begin
            scr = scroll_pos;
            if (line_cnt != '0) begin
                line_cnt     = line_cnt - rts_pkg::CNT_W'(1);
                w            = '0;
                w.scroll     = scr;
                w.last       = 1'b1;
                tile_writes_q.push_back(w);
            end else begin
                decode_row(scr);
            end
            if (scroll_pos != '0) begin
                scroll_pos = scroll_pos - rts_pkg::SCR_W'(1);
            end else begin
                scroll_pos = rts_pkg::SCR_W'(rts_pkg::SCROLL_LINES - 1);
            end
        end
    endtask

    task automatic apb_write(input logic idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == rts_pkg::REG_LEVEL_START) begin
            lvl_start = val[rts_pkg::MAP_AW-1:0];
            rd_ptr    = lvl_start;
        end else begin
            tile_base = val[rts_pkg::BASE_W-1:0];
        end
        @(negedge i_clk);
    endtask

    // Hold until nothing is queued, in flight or expected, then idle a while longer
    task automatic drain_and_settle(input int extra);
        while (item_q.size() != 0 || item_if.valid || tile_writes_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (extra) @(negedge i_clk);
    endtask

    // Well-formed rows at the level start, closed by the end mark
    task automatic push_level(input int rows_n);
        logic [rts_pkg::ADDR_W-1:0] a;
        int filled;
        int n;
        int pick;
        a       = lvl_start;
        lvl_len = 0;
        for (int r = 0; r < rows_n; r++) begin
            filled = 0;
            while (filled < rts_pkg::ROW_CHARS) begin
                pick = $urandom_range(0, 9);
                if (pick < 5) begin
                    push_item(rts_pkg::OP_LOAD, a, rts_pkg::BYTE_W'($urandom_range(0, 127)));
                    a++;
                    lvl_len++;
                    filled++;
                end else begin
                    n = (pick == 5) ? 0 : $urandom_range(1, 20);
                    push_item(rts_pkg::OP_LOAD, a, rts_pkg::BYTE_W'(8'h80 | n));
                    a++;
                    push_item(rts_pkg::OP_LOAD, a, rts_pkg::BYTE_W'($urandom_range(0, 255)));
                    a++;
                    lvl_len += 2;
                    filled += n;
                end
            end
        end
        push_item(rts_pkg::OP_LOAD, a, rts_pkg::END_MARK);
        lvl_len++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Item driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (item_if.valid && item_if.ready) begin
                scroller_step(cur_item);
            end
            if (!item_if.valid || item_if.ready) begin
                if (gap_left > 0) begin
                    item_if.valid <= 1'b0;
                    gap_left--;
                end else if (item_q.size() > 0) begin
                    cur_item = item_q.pop_front();
                    item_if.valid        <= 1'b1;
                    item_if.opcode       <= cur_item.op;
                    item_if.load_address <= cur_item.addr;
                    item_if.load_byte    <= cur_item.data;
                    gap_left = $urandom_range(0, src_idle_max);
                end else begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver
    always @(posedge i_clk) begin
        t_tile_write got;
        t_tile_write want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                got.tile_valid = res_if.tile_valid;
                got.col        = res_if.tile_column;
                got.row        = res_if.tile_row;
                got.tile       = res_if.tile_value;
                got.scroll     = res_if.scroll_value;
                got.last       = res_if.last;
                res_n++;
                if (tile_writes_q.size() == 0) begin
                    flag_mismatch($sformatf("result %0d arrived with nothing expected", res_n));
                end else begin
                    want = tile_writes_q.pop_front();
                    if (got !== want) begin
                        flag_mismatch($sformatf("result %0d: got %h, want %h",
                                                res_n, got, want));
                    end
                end
                stall_left = $urandom_range(0, snk_idle_max);
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (hold_taken_n != hold_req_n) begin
                hold_taken_n++;
                hold_left = HOLD_CYCLES;
                res_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog: count cycles with no handshake on any port
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_n = 0;
        end else if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
                     (psel && penable)) begin
            quiet_n = 0;
        end else begin
            quiet_n++;
            if (quiet_n >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        logic [rts_pkg::BYTE_W-1:0] row_bytes [11];
        logic [rts_pkg::ADDR_W-1:0] a;
        int n_items;
        int pick;
        item_if.valid        = 1'b0;
        item_if.opcode       = rts_pkg::OP_LOAD;
        item_if.load_address = '0;
        item_if.load_byte    = '0;
        res_if.ready         = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        i_rst_n              = 1'b0;
        err_n        = 0;
        res_n        = 0;
        hold_req_n   = 0;
        hold_taken_n = 0;
        src_idle_max = 0;
        snk_idle_max = 0;
        lvl_len      = 0;
        lvl_start    = '0;
        tile_base    = rts_pkg::TILE_BASE_RST;
        rd_ptr       = '0;
        row_pos      = rts_pkg::ROW_W'(rts_pkg::SCROLL_CHAR_ROWS - 2);
        line_cnt     = '0;
        scroll_pos   = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed row wrapping past the top of the map: literals, clipped and empty runs
        apb_write(rts_pkg::REG_LEVEL_START, 32'd4090);
        apb_write(rts_pkg::REG_TILE_BASE, 32'd511);
        src_idle_max = 10;
        snk_idle_max = 10;
        row_bytes = '{8'h00, 8'h7F, 8'h83, 8'hFF, 8'h80, 8'h55, 8'h85, 8'hAA, 8'hFF, 8'h12,
                      rts_pkg::END_MARK};
        for (int i = 0; i < 11; i++) begin
            push_item(rts_pkg::OP_LOAD, rts_pkg::ADDR_W'(4090 + i), row_bytes[i]);
        end
        repeat (16) push_tick();
        drain_and_settle(20);

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    apb_write(rts_pkg::REG_LEVEL_START, 32'd4095);
                    apb_write(rts_pkg::REG_TILE_BASE, 32'd0);
                end
                1: begin
                    apb_write(rts_pkg::REG_LEVEL_START, 32'd0);
                    apb_write(rts_pkg::REG_TILE_BASE, 32'd511);
                end
                default: begin
                    apb_write(rts_pkg::REG_LEVEL_START, $urandom_range(0, 4095));
                    apb_write(rts_pkg::REG_TILE_BASE, $urandom_range(0, 511));
                end
            endcase
            src_idle_max = $urandom_range(0, 1) ? 10 : 0;
            snk_idle_max = $urandom_range(0, 1) ? 10 : 0;
            push_level($urandom_range(1, 3));
            n_items = item_q.size();
            while (n_items < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 80) begin
                    push_tick();
                end else begin
                    // stray byte outside the level, so every row read stays written
                    a = rts_pkg::ADDR_W'($urandom_range(0, 4095 - lvl_len));
                    a = a + lvl_start + rts_pkg::ADDR_W'(lvl_len);
                    push_item(rts_pkg::OP_LOAD, a, rts_pkg::BYTE_W'($urandom_range(0, 255)));
                end
                n_items++;
            end
            if (ph == 1 || ph == 3) begin
                hold_req_n++;
            end
            drain_and_settle(20);
        end

        drain_and_settle(100);
        if (err_n == 0 && tile_writes_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: files.f
design/rts_pkg.sv
design/rts_item_if.sv
design/rts_ram.sv
design/rts_ctrl.sv
design/rts_datapath.sv
design/rle_tilemap_row_scroller.sv
test/rle_tilemap_row_scroller_tb.sv
